>>> rtl/sequence_checked_command_ledger_unit_assert.svh
// Assertion macros shared by the ledger checker.
`ifndef SEQUENCE_CHECKED_COMMAND_LEDGER_UNIT_ASSERT_SVH
`define SEQUENCE_CHECKED_COMMAND_LEDGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCCL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SCCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/sccl_pkg.sv
// Shared types and constants for the command ledger.
package sccl_pkg;

  localparam int FIELD_W     = 32;
  localparam int PEND_W      = 9;
  localparam int TOL_W       = 16;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 144;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ISSUE    = 2'd0;
  localparam kind_t KIND_DISPATCH = 2'd1;
  localparam kind_t KIND_LINK     = 2'd2;
  localparam kind_t KIND_TRIAL    = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_MISMATCH = 2'd1;
  localparam status_t STATUS_OVERFLOW = 2'd2;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_REQUIRE_DISPATCH = 1'd0;
  localparam reg_idx_t REG_MATCH_TOL        = 1'd1;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/sccl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sccl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/sccl_ctrl.sv
// Controller: accepts one word, then evaluates it in the EXEC state before accepting another.
module sccl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  sccl_pkg::dp_status_t   dp_stat,
  output sccl_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == ST_IDLE) && dp_stat.out_free;
  assign cmd.accept = in_tvalid && in_tready;
  assign cmd.exec   = (state_r == ST_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sccl_dpath.sv
// Datapath: item latch, command memory, ledger state, config and output register.
module sccl_dpath #(
  parameter int LEDGER_DEPTH = 256,
  parameter int CMD_WIDTH    = 32,
  parameter int SEQ_WIDTH    = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sccl_pkg::ctrl_cmd_t                cmd,
  output sccl_pkg::dp_status_t               dp_stat,
  input  logic [sccl_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [1:0]                         in_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [sccl_pkg::TOL_W-1:0]         cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sccl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [1:0]                         out_tuser
);

  localparam int AW    = $clog2(LEDGER_DEPTH);
  localparam int CNT_W = $clog2(LEDGER_DEPTH + 1);
  localparam int CMPW  = (CMD_WIDTH > sccl_pkg::TOL_W) ? CMD_WIDTH : sccl_pkg::TOL_W;
  localparam int FW    = sccl_pkg::FIELD_W;

  // latched item
  sccl_pkg::kind_t             kind_r;
  logic signed [CMD_WIDTH-1:0] cx_r, cy_r, ct_r;
  logic                        has_seq_r;
  logic [SEQ_WIDTH-1:0]        seq_r;
  logic                        link_r;

  // ledger state
  logic [AW-1:0]               head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic [SEQ_WIDTH-1:0]        exp_r, exp_nxt;
  logic                        seq_ready_r, seq_ready_nxt;
  logic                        ledger_r, ledger_nxt;
  logic                        transport_r, transport_nxt;
  logic                        observed_r, observed_nxt;
  logic signed [CMD_WIDTH-1:0] held_x_r, held_x_nxt;
  logic signed [CMD_WIDTH-1:0] held_y_r, held_y_nxt;
  logic signed [CMD_WIDTH-1:0] held_t_r, held_t_nxt;
  sccl_pkg::status_t           status_nxt;

  // config
  logic                        req_disp_r;
  logic [sccl_pkg::TOL_W-1:0]  tol_r;

  // output register
  logic                        out_valid_r;
  sccl_pkg::status_t           out_status_r;
  logic                        out_snap_r, out_ledger_r, out_transport_r, out_observed_r;
  logic [sccl_pkg::PEND_W-1:0] out_pend_r;
  logic [FW-1:0]               out_seq_r, out_x_r, out_y_r, out_t_r;

  // memory
  logic                        ram_wr_en;
  logic [3*CMD_WIDTH-1:0]      ram_rd_data;
  logic [CMD_WIDTH-1:0]        head_x, head_y, head_t;

  logic                        full, empty;
  logic                        close_zero, close_head, dispatch_ok;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(LEDGER_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // Sign flip gives an order-preserving unsigned code; compare distance with tolerance.
  function automatic logic axis_close(input logic [CMD_WIDTH-1:0] a,
                                      input logic [CMD_WIDTH-1:0] b,
                                      input logic [sccl_pkg::TOL_W-1:0] tol);
    logic [CMD_WIDTH-1:0] oa, ob, d;
    oa = a ^ {1'b1, {(CMD_WIDTH-1){1'b0}}};
    ob = b ^ {1'b1, {(CMD_WIDTH-1){1'b0}}};
    d  = (oa >= ob) ? (oa - ob) : (ob - oa);
    return CMPW'(d) <= CMPW'(tol);
  endfunction

  assign dp_stat.out_free = !out_valid_r || out_tready;
  assign cfg_ready        = 1'b1;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_tuser;
      cx_r      <= CMD_WIDTH'($signed(in_tdata[31:0]));
      cy_r      <= CMD_WIDTH'($signed(in_tdata[63:32]));
      ct_r      <= CMD_WIDTH'($signed(in_tdata[95:64]));
      has_seq_r <= in_tdata[96];
      seq_r     <= SEQ_WIDTH'(in_tdata[128:97]);
      link_r    <= in_tdata[129];
    end
  end

  assign full      = (fill_r == CNT_W'(LEDGER_DEPTH));
  assign empty     = (fill_r == '0);
  assign ram_wr_en = cmd.exec && (kind_r == sccl_pkg::KIND_ISSUE) && !full;

  // head is read at accept, data is ready in the evaluate cycle
  sccl_ram #(
    .WIDTH (3 * CMD_WIDTH),
    .DEPTH (LEDGER_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data ({ct_r, cy_r, cx_r}),
    .rd_en   (cmd.accept),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  assign head_x = ram_rd_data[CMD_WIDTH-1:0];
  assign head_y = ram_rd_data[2*CMD_WIDTH-1:CMD_WIDTH];
  assign head_t = ram_rd_data[3*CMD_WIDTH-1:2*CMD_WIDTH];

  assign close_zero = axis_close(cx_r, '0, tol_r) && axis_close(cy_r, '0, tol_r) &&
                      axis_close(ct_r, '0, tol_r);
  assign close_head = axis_close(head_x, cx_r, tol_r) && axis_close(head_y, cy_r, tol_r) &&
                      axis_close(head_t, ct_r, tol_r);
  assign dispatch_ok = has_seq_r ? (seq_ready_r && (seq_r == exp_r) && !empty && close_head)
                                 : close_zero;

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    exp_nxt       = exp_r;
    seq_ready_nxt = seq_ready_r;
    ledger_nxt    = ledger_r;
    transport_nxt = transport_r;
    observed_nxt  = observed_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    held_t_nxt    = held_t_r;
    status_nxt    = sccl_pkg::STATUS_OK;
    case (kind_r)
      sccl_pkg::KIND_ISSUE: begin
        if (full) begin
          transport_nxt = 1'b0;
          head_nxt      = '0;
          tail_nxt      = '0;
          fill_nxt      = '0;
          status_nxt    = sccl_pkg::STATUS_OVERFLOW;
        end else begin
          tail_nxt = ptr_inc(tail_r);
          fill_nxt = fill_r + 1'b1;
        end
      end
      sccl_pkg::KIND_DISPATCH: begin
        if (!has_seq_r) begin
          head_nxt      = '0;
          tail_nxt      = '0;
          fill_nxt      = '0;
          exp_nxt       = '0;
          seq_ready_nxt = 1'b1;
          ledger_nxt    = close_zero;
        end else if (dispatch_ok) begin
          head_nxt   = ptr_inc(head_r);
          fill_nxt   = fill_r - 1'b1;
          exp_nxt    = exp_r + 1'b1;
          ledger_nxt = 1'b1;
        end else begin
          head_nxt   = '0;
          tail_nxt   = '0;
          fill_nxt   = '0;
          ledger_nxt = 1'b0;
        end
        if (dispatch_ok) begin
          held_x_nxt   = cx_r;
          held_y_nxt   = cy_r;
          held_t_nxt   = ct_r;
          observed_nxt = 1'b1;
        end else begin
          status_nxt = sccl_pkg::STATUS_MISMATCH;
        end
      end
      sccl_pkg::KIND_LINK: begin
        transport_nxt = link_r;
        if (!link_r) begin
          observed_nxt  = 1'b0;
          ledger_nxt    = 1'b0;
          seq_ready_nxt = 1'b0;
          head_nxt      = '0;
          tail_nxt      = '0;
          fill_nxt      = '0;
        end
      end
      default: begin
        head_nxt      = '0;
        tail_nxt      = '0;
        fill_nxt      = '0;
        held_x_nxt    = '0;
        held_y_nxt    = '0;
        held_t_nxt    = '0;
        observed_nxt  = 1'b1;
        transport_nxt = 1'b1;
        ledger_nxt    = 1'b1;
        seq_ready_nxt = 1'b1;
        exp_nxt       = '0;
      end
    endcase
  end

  // ledger state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      exp_r       <= '0;
      seq_ready_r <= 1'b0;
      ledger_r    <= 1'b0;
      transport_r <= 1'b0;
      observed_r  <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_t_r    <= '0;
      req_disp_r  <= 1'b1;
      tol_r       <= '0;
    end else begin
      if (cmd.exec) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        fill_r      <= fill_nxt;
        exp_r       <= exp_nxt;
        seq_ready_r <= seq_ready_nxt;
        ledger_r    <= ledger_nxt;
        transport_r <= transport_nxt;
        observed_r  <= observed_nxt;
        held_x_r    <= held_x_nxt;
        held_y_r    <= held_y_nxt;
        held_t_r    <= held_t_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sccl_pkg::REG_REQUIRE_DISPATCH: req_disp_r <= cfg_data[0];
          sccl_pkg::REG_MATCH_TOL:        tol_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r    <= status_nxt;
      out_snap_r      <= transport_nxt && ledger_nxt && (observed_nxt || !req_disp_r);
      out_ledger_r    <= ledger_nxt;
      out_transport_r <= transport_nxt;
      out_observed_r  <= observed_nxt;
      out_pend_r      <= sccl_pkg::PEND_W'(fill_nxt);
      out_seq_r       <= FW'(exp_nxt);
      out_x_r         <= FW'(held_x_nxt);
      out_y_r         <= FW'(held_y_nxt);
      out_t_r         <= FW'(held_t_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_t_r, out_y_r, out_x_r, out_seq_r, out_pend_r,
                       out_observed_r, out_transport_r, out_ledger_r, out_snap_r};

endmodule

>>> rtl/sequence_checked_command_ledger_unit.sv
// Top level of the sequence-checked command ledger.
// In-order scoreboard for issued three-axis commands. Each input word passes
// through an accept cycle, which also reads the FIFO head from the command
// memory (registered read), and then an evaluate cycle that updates the ledger
// and loads the output register. A new word is taken once the controller is idle
// and the output register is empty or being drained, so no new word is taken
// while one is being evaluated. The command memory needs no clearing pass after
// reset: the fill count keeps unwritten entries from being read. Config writes
// are always ready and belong in idle periods only.
module sequence_checked_command_ledger_unit #(
  parameter int LEDGER_DEPTH = 256,
  parameter int CMD_WIDTH    = 32,
  parameter int SEQ_WIDTH    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] cmd_linear_x, [63:32] cmd_linear_y, [95:64] cmd_angular,
  // [96] has_seq, [128:97] seq_number, [129] link_ok, [135:130] zero
  input  logic [sccl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]                       in_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [sccl_pkg::TOL_W-1:0]       cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] snapshot_ok, [1] ledger_ok, [2] transport_ok, [3] observed,
  // [12:4] pending_count, [44:13] next_seq, [76:45] last_x, [108:77] last_y,
  // [140:109] last_turn, [143:141] zero
  output logic [sccl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]                       out_tuser
);

  sccl_pkg::ctrl_cmd_t  cmd;
  sccl_pkg::dp_status_t dp_stat;

  sccl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  sccl_dpath #(
    .LEDGER_DEPTH (LEDGER_DEPTH),
    .CMD_WIDTH    (CMD_WIDTH),
    .SEQ_WIDTH    (SEQ_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .dp_stat    (dp_stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/sccl_checker.sv
// Port-level checker for the command ledger, bound to the top level.
`include "sequence_checked_command_ledger_unit_assert.svh"

module sccl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sccl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser
);

  logic snap, ledger, transport;
  logic ovf_word, mism_word;
  logic [sccl_pkg::PEND_W-1:0] pend;

  assign snap      = out_tdata[0];
  assign ledger    = out_tdata[1];
  assign transport = out_tdata[2];
  assign pend      = out_tdata[12:4];
  assign ovf_word  = out_tvalid && (out_tuser == sccl_pkg::STATUS_OVERFLOW);
  assign mism_word = out_tvalid && (out_tuser == sccl_pkg::STATUS_MISMATCH);

  // snapshot needs both validity flags
  `SCCL_ASSERT_IMPL(a_snap_flags, out_tvalid && snap, ledger && transport)
  // overflow drops transport and empties the ledger
  `SCCL_ASSERT_IMPL(a_overflow, ovf_word, !transport && (pend == '0))
  // a rejected dispatch leaves an invalid, empty ledger
  `SCCL_ASSERT_IMPL(a_mismatch, mism_word, !ledger && (pend == '0))
  // a stalled result word holds
  `SCCL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind sequence_checked_command_ledger_unit sccl_checker u_sccl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
